FILE: rtl/lef_pkg.sv
// Shared types and constants for the 3x3 Laplacian edge filter.
// No dependencies; used by every module of the block but lef_line_ram.
`default_nettype none
package lef_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int WIDTH_W    = 13;
  localparam int HEIGHT_W   = 16;
  localparam int CHAN_W     = 8;
  localparam int NUM_LANES  = 3;
  localparam int PIX_W      = CHAN_W * NUM_LANES;
  localparam int CFG_W      = 16;

  localparam logic [WIDTH_W-1:0]  WIDTH_RST  = WIDTH_W'(640);
  localparam logic [HEIGHT_W-1:0] HEIGHT_RST = HEIGHT_W'(480);
  localparam logic [WIDTH_W-1:0]  WIDTH_MIN  = WIDTH_W'(3);
  localparam logic [WIDTH_W-1:0]  WIDTH_MAX  = WIDTH_W'(MAX_WIDTH);
  localparam logic [HEIGHT_W-1:0] HEIGHT_MIN = HEIGHT_W'(3);

  typedef enum logic [0:0] {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic line_end;
    logic frame_end;
  } flags_t;

  typedef logic [NUM_LANES-1:0][CHAN_W-1:0] lanes_t;

endpackage
`default_nettype wire

FILE: rtl/lef_line_ram.sv
// Simple dual-port line memory: one write port, one registered read port.
// Generic; no package dependency.
`default_nettype none
module lef_line_ram #(
  parameter int DW = 48,
  parameter int AW = 12
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/lef_lane.sv
// One color channel: keeps its two older window columns and forms the
// saturated eight-neighbor Laplacian. Depends on lef_pkg.
`default_nettype none
module lef_lane (
  input  wire logic                        clk,
  input  wire logic                        step,
  input  wire logic [lef_pkg::CHAN_W-1:0] top,
  input  wire logic [lef_pkg::CHAN_W-1:0] mid,
  input  wire logic [lef_pkg::CHAN_W-1:0] bot,
  output logic      [lef_pkg::CHAN_W-1:0] result
);

  // win_r: 0,1 top row; 2,3 middle row; 4,5 bottom row (oldest first)
  logic [lef_pkg::CHAN_W-1:0] win_r [6];

  logic [11:0] center;
  logic [11:0] ring;
  logic signed [12:0] diff;

  always_ff @(posedge clk) begin
    if (step) begin
      win_r[0] <= win_r[1];
      win_r[1] <= top;
      win_r[2] <= win_r[3];
      win_r[3] <= mid;
      win_r[4] <= win_r[5];
      win_r[5] <= bot;
    end
  end

  always_comb begin
    center = {1'b0, win_r[3], 3'b000};
    ring   = 12'(win_r[0]) + 12'(win_r[1]) + 12'(top)
           + 12'(win_r[2]) + 12'(mid)
           + 12'(win_r[4]) + 12'(win_r[5]) + 12'(bot);
    diff   = $signed({1'b0, center}) - $signed({1'b0, ring});
    if (diff < 0) begin
      result = '0;
    end else if (diff > 13'sd255) begin
      result = '1;
    end else begin
      result = diff[lef_pkg::CHAN_W-1:0];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/lef_merge.sv
// Output register: gathers the lane results and row/frame flags into one
// result item and holds it while the receiver stalls. Depends on lef_pkg.
`default_nettype none
module lef_merge (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        load,
  input  wire lef_pkg::lanes_t             lanes,
  input  wire lef_pkg::flags_t             flags,
  input  wire logic                        out_stall,
  output logic                             out_valid,
  output logic [lef_pkg::CHAN_W-1:0]      out_blue_out,
  output logic [lef_pkg::CHAN_W-1:0]      out_green_out,
  output logic [lef_pkg::CHAN_W-1:0]      out_red_out,
  output logic                             out_line_end,
  output logic                             out_frame_end
);

  logic            valid_r;
  logic            valid_nxt;
  lef_pkg::lanes_t lanes_r;
  lef_pkg::flags_t flags_r;

  always_comb begin
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_stall) begin
      valid_nxt = valid_r;
    end else begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      lanes_r <= lanes;
      flags_r <= flags;
    end
  end

  assign out_valid     = valid_r;
  assign out_blue_out  = lanes_r[0];
  assign out_green_out = lanes_r[1];
  assign out_red_out   = lanes_r[2];
  assign out_line_end  = flags_r.line_end;
  assign out_frame_end = flags_r.frame_end;

endmodule
`default_nettype wire

FILE: rtl/laplacian_edge_filter_3x3.sv
// Top level of the 3x3 eight-neighbor Laplacian filter on an RGB stream.
// Depends on lef_pkg, lef_line_ram, lef_lane and lef_merge.
//
// Usage:
//  - Input channel: in_valid / in_stall with one RGB pixel per item, raster
//    order. An item is taken at a clock edge with in_valid high and
//    in_stall low.
//  - Result channel: out_valid / out_stall. One result per input pixel whose
//    row and column are both at least 2, so the output frame is
//    (width-2) x (height-2). out_line_end marks the last result of a line,
//    out_frame_end the last of the frame.
//  - Config: cfg_we with cfg_index (0 = width, 1 = height) and cfg_wdata.
//    Width is clamped to 3..4096, height to at least 3. Write only while idle.
//  - Throughput: one item per clock while the output does not stall. The
//    line memory is read at the edge that takes the item, then the lane
//    add tree feeds the output register when the item advances.
//  - Stall: the output register holds its item; one more item can wait in
//    the read stage, after which in_stall rises.
//  - Reset (rst_n low, synchronous): counters go to row 0 / column 0, the
//    pipeline empties and config returns to 640 x 480. Line memories are
//    not cleared; the first two rows of a frame fill them before use.
`default_nettype none
module laplacian_edge_filter_3x3 (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic                          cfg_index,
  input  wire logic [lef_pkg::CFG_W-1:0]    cfg_wdata,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [lef_pkg::CHAN_W-1:0]   in_blue_in,
  input  wire logic [lef_pkg::CHAN_W-1:0]   in_green_in,
  input  wire logic [lef_pkg::CHAN_W-1:0]   in_red_in,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [lef_pkg::CHAN_W-1:0]        out_blue_out,
  output logic [lef_pkg::CHAN_W-1:0]        out_green_out,
  output logic [lef_pkg::CHAN_W-1:0]        out_red_out,
  output logic                               out_line_end,
  output logic                               out_frame_end
);

  localparam int COL_W    = lef_pkg::COL_W;
  localparam int WIDTH_W  = lef_pkg::WIDTH_W;
  localparam int HEIGHT_W = lef_pkg::HEIGHT_W;
  localparam int PIX_W    = lef_pkg::PIX_W;
  localparam int CHAN_W   = lef_pkg::CHAN_W;

  // ---- configuration registers ----
  logic [WIDTH_W-1:0]  width_r;
  logic [HEIGHT_W-1:0] height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= lef_pkg::WIDTH_RST;
      height_r <= lef_pkg::HEIGHT_RST;
    end else if (cfg_we) begin
      case (lef_pkg::cfg_idx_t'(cfg_index))
        lef_pkg::CFG_WIDTH:  width_r  <= cfg_wdata[WIDTH_W-1:0];
        lef_pkg::CFG_HEIGHT: height_r <= cfg_wdata[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // ---- position counters (stage 0) ----
  logic [COL_W-1:0]    col_r, col_nxt;
  logic [HEIGHT_W-1:0] row_r, row_nxt;
  logic [WIDTH_W-1:0]  w_eff, w_last;
  logic [HEIGHT_W-1:0] h_eff, h_last;
  logic [COL_W-1:0]    col;
  logic [HEIGHT_W-1:0] row;
  logic                last_col, last_row, emit;
  logic                in_acc;

  always_comb begin
    if (width_r < lef_pkg::WIDTH_MIN) begin
      w_eff = lef_pkg::WIDTH_MIN;
    end else if (width_r > lef_pkg::WIDTH_MAX) begin
      w_eff = lef_pkg::WIDTH_MAX;
    end else begin
      w_eff = width_r;
    end
    h_eff  = (height_r < lef_pkg::HEIGHT_MIN) ? lef_pkg::HEIGHT_MIN : height_r;
    w_last = w_eff - WIDTH_W'(1);
    h_last = h_eff - HEIGHT_W'(1);

    // a count left past the end by a smaller config wraps as a line end
    col = ({1'b0, col_r} >= w_eff) ? w_last[COL_W-1:0] : col_r;
    row = (row_r >= h_eff) ? h_last : row_r;

    last_col = (col == w_last[COL_W-1:0]);
    last_row = (row == h_last);
    emit     = (row >= HEIGHT_W'(2)) && (col >= COL_W'(2));

    if (last_col) begin
      col_nxt = '0;
      row_nxt = last_row ? '0 : row + HEIGHT_W'(1);
    end else begin
      col_nxt = col + COL_W'(1);
      row_nxt = row;
    end
  end

  assign in_acc = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // ---- stage 1: line memory data arrives, lanes compute ----
  logic               s1_valid_r;
  logic               s1_emit_r;
  lef_pkg::flags_t    s1_flags_r;
  logic [COL_W-1:0]   s1_col_r;
  logic [PIX_W-1:0]   s1_bot_r;
  logic               s1_adv;
  logic [2*PIX_W-1:0] ram_rdata;
  logic [PIX_W-1:0]   s1_top, s1_mid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_emit_r            <= emit;
      s1_flags_r.line_end  <= last_col;
      s1_flags_r.frame_end <= last_col && last_row;
      s1_col_r             <= col;
      s1_bot_r             <= {in_red_in, in_green_in, in_blue_in};
    end
  end

  // items without a result never wait on the output register
  assign s1_adv   = s1_valid_r && (!s1_emit_r || !out_valid || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;

  // both older lines share one entry: upper half two lines up, lower one up
  assign s1_top = ram_rdata[2*PIX_W-1:PIX_W];
  assign s1_mid = ram_rdata[PIX_W-1:0];

  lef_line_ram #(
    .DW (2 * PIX_W),
    .AW (COL_W)
  ) u_line_ram (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_col_r),
    .wdata ({s1_mid, s1_bot_r}),
    .re    (in_acc),
    .raddr (col),
    .rdata (ram_rdata)
  );

  lef_pkg::lanes_t lane_res;

  for (genvar c = 0; c < lef_pkg::NUM_LANES; c++) begin : g_lane
    lef_lane u_lane (
      .clk    (clk),
      .step   (s1_adv),
      .top    (s1_top[c*CHAN_W +: CHAN_W]),
      .mid    (s1_mid[c*CHAN_W +: CHAN_W]),
      .bot    (s1_bot_r[c*CHAN_W +: CHAN_W]),
      .result (lane_res[c])
    );
  end

  // ---- stage 2: output register ----
  lef_merge u_merge (
    .clk           (clk),
    .rst_n         (rst_n),
    .load          (s1_adv && s1_emit_r),
    .lanes         (lane_res),
    .flags         (s1_flags_r),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .out_blue_out  (out_blue_out),
    .out_green_out (out_green_out),
    .out_red_out   (out_red_out),
    .out_line_end  (out_line_end),
    .out_frame_end (out_frame_end)
  );

endmodule
`default_nettype wire

FILE: rtl/lef_checker.sv
// Port-level checks for laplacian_edge_filter_3x3, bound to the top level.
// Depends on lef_pkg.
`default_nettype none
module lef_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_stall,
  input wire logic                        out_valid,
  input wire logic                        out_stall,
  input wire logic [lef_pkg::CHAN_W-1:0] out_blue_out,
  input wire logic [lef_pkg::CHAN_W-1:0] out_green_out,
  input wire logic [lef_pkg::CHAN_W-1:0] out_red_out,
  input wire logic                        out_line_end,
  input wire logic                        out_frame_end
);

  // a frame end is always also a line end
  a_frame_is_line: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_frame_end || out_line_end))
    else $error("frame_end without line_end");

  // result register empties on reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid after reset");

  // with no result pending the input side never stalls
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_blue_out)
      && $stable(out_green_out) && $stable(out_red_out)
      && $stable(out_line_end) && $stable(out_frame_end)))
    else $error("stalled result changed");

endmodule

bind laplacian_edge_filter_3x3 lef_checker u_lef_checker (.*);
`default_nettype wire
